// ----- src/ptst_pkg.sv -----
// Package for the periodic timer slot table: sizes, codes and shared types.
package ptst_pkg;

  localparam int SLOTS = 16;
  localparam int CNT_W = $clog2(SLOTS);
  localparam int ID_W = 24;
  localparam int DLY_W = 32;
  localparam logic [ID_W-1:0] ID_WRAP = 24'd9999999;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Contents of one timer slot.
  typedef struct packed {
    logic                    valid;
    logic                    stage;
    logic signed [DLY_W-1:0] remaining;
    logic signed [DLY_W-1:0] repeat_dly;
    logic [ID_W-1:0]         ident;
  } slot_t;

  // The request being worked on.
  typedef struct packed {
    logic [1:0]              req_type;
    logic                    stage;
    logic [30:0]             elapsed;
    logic [30:0]             first_delay;
    logic signed [DLY_W-1:0] repeat_delay;
    logic [ID_W-1:0]         task_id;
  } req_t;

  // What the head unit did with the slot passing through it.
  typedef struct packed {
    logic fire;
    logic claim;
    logic match;
  } head_stat_t;

  function automatic logic [ID_W-1:0] id_after(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] nxt;
    nxt = id + 1'b1;
    return (nxt >= ID_WRAP) ? '0 : nxt;
  endfunction

endpackage

// ----- src/ptst_cell.sv -----
// One cell of the slot ring: holds a slot and passes it on while the ring turns.
module ptst_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  ptst_pkg::slot_t       slot_in,
  output ptst_pkg::slot_t       slot_out
);

  logic                              valid_r;
  logic                              stage_r;
  logic signed [ptst_pkg::DLY_W-1:0] remaining_r;
  logic signed [ptst_pkg::DLY_W-1:0] repeat_r;
  logic [ptst_pkg::ID_W-1:0]         ident_r;

  // Only the valid bit is reset; the payload is meaningless while it is clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= slot_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      stage_r     <= slot_in.stage;
      remaining_r <= slot_in.remaining;
      repeat_r    <= slot_in.repeat_dly;
      ident_r     <= slot_in.ident;
    end
  end

  always_comb begin
    slot_out.valid      = valid_r;
    slot_out.stage      = stage_r;
    slot_out.remaining  = remaining_r;
    slot_out.repeat_dly = repeat_r;
    slot_out.ident      = ident_r;
  end

endmodule

// ----- src/ptst_head.sv -----
// Head unit of the slot ring: applies the current request to one slot.
module ptst_head (
  input  ptst_pkg::req_t                 req,
  input  logic                           taken,
  input  logic                           hit,
  input  logic [ptst_pkg::ID_W-1:0]      next_id,
  input  ptst_pkg::slot_t                slot_in,
  output ptst_pkg::slot_t                slot_out,
  output ptst_pkg::head_stat_t           stat
);

  logic signed [ptst_pkg::DLY_W:0] diff;

  // A negative result can only come from a slot that fires, and a firing slot
  // is reloaded or freed, so the wrapped low bits are never kept.
  assign diff = {slot_in.remaining[ptst_pkg::DLY_W-1], slot_in.remaining}
              - $signed({2'b00, req.elapsed});

  always_comb begin
    slot_out = slot_in;
    stat     = '0;
    case (req.req_type)
      ptst_pkg::REQ_TICK: begin
        if (slot_in.valid && (slot_in.stage == req.stage)) begin
          if (diff[ptst_pkg::DLY_W]) begin
            stat.fire = 1'b1;
            if (slot_in.repeat_dly[ptst_pkg::DLY_W-1]) begin
              slot_out.valid = 1'b0;
            end else begin
              slot_out.remaining = slot_in.repeat_dly;
            end
          end else begin
            slot_out.remaining = diff[ptst_pkg::DLY_W-1:0];
          end
        end
      end
      ptst_pkg::REQ_ADD: begin
        if (!slot_in.valid && !taken) begin
          stat.claim          = 1'b1;
          slot_out.valid      = 1'b1;
          slot_out.stage      = req.stage;
          slot_out.remaining  = $signed({1'b0, req.first_delay});
          slot_out.repeat_dly = req.repeat_delay;
          slot_out.ident      = next_id;
        end
      end
      ptst_pkg::REQ_REMOVE: begin
        if (slot_in.valid && !hit && (slot_in.ident == req.task_id)) begin
          stat.match     = 1'b1;
          slot_out.valid = 1'b0;
        end
      end
      default: begin
        slot_out.valid = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/periodic_timer_slot_table.sv -----
// Top level of the periodic timer slot table: slot ring, head unit and control.
//
// The block keeps SLOTS timer slots in a ring of cells. A request is accepted
// at a rising edge where start is high and busy is low; its fields sit on the
// in_ ports. Once accepted, the ring turns once around: at each shift the
// slot in the front cell passes through the head unit, which applies the
// request to it, and moves to the back of the ring. After a full
// turn every slot is back in its own cell, and the slots were seen in slot
// order, so firings come out lowest slot first.
//
// Results appear on the out_ ports for exactly one cycle, marked by
// out_strobe; the receiver cannot hold them off. A tick gives one fired
// transaction per expiring slot (out_last low) and then a done transaction
// (out_last high). Add, remove and clear give one transaction each.
// An item's final result follows the one turn of the ring; busy drops so
// that the next request can be accepted at the very edge that launches the
// final result. After reset every slot is free and the id counter is zero.
module periodic_timer_slot_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic                            in_stage,
  input  logic [30:0]                     in_elapsed,
  input  logic [30:0]                     in_first_delay,
  input  logic signed [31:0]              in_repeat_delay,
  input  logic [23:0]                     in_task_id,
  output logic                            out_strobe,
  output logic [1:0]                      out_kind,
  output logic [23:0]                     out_task_id_res,
  output logic                            out_found,
  output logic                            out_last
);

  // Ring of slot cells. Cell 0 is the front; the head unit feeds the back.
  ptst_pkg::slot_t      ring_q [ptst_pkg::SLOTS];
  ptst_pkg::slot_t      head_out;
  ptst_pkg::head_stat_t head_stat;

  // Control registers.
  logic                            busy_r, busy_nxt;
  logic                            pend_r, pend_nxt;
  logic [ptst_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  ptst_pkg::req_t                  req_r, req_nxt;
  logic                            taken_r, taken_nxt;
  logic                            hit_r, hit_nxt;
  logic [ptst_pkg::ID_W-1:0]       res_id_r, res_id_nxt;
  logic [ptst_pkg::ID_W-1:0]       next_id_r, next_id_nxt;

  // Result registers.
  logic                            strobe_r, strobe_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [ptst_pkg::ID_W-1:0]       id_r, id_nxt;
  logic                            found_r, found_nxt;
  logic                            last_r, last_nxt;

  logic accept;

  assign accept = start && !busy_r;

  for (genvar k = 0; k < ptst_pkg::SLOTS; k++) begin : g_ring
    ptst_pkg::slot_t cell_in;
    if (k == ptst_pkg::SLOTS - 1) begin : g_back
      assign cell_in = head_out;
    end else begin : g_mid
      assign cell_in = ring_q[k+1];
    end
    ptst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (busy_r),
      .slot_in  (cell_in),
      .slot_out (ring_q[k])
    );
  end

  ptst_head u_head (
    .req      (req_r),
    .taken    (taken_r),
    .hit      (hit_r),
    .next_id  (next_id_r),
    .slot_in  (ring_q[0]),
    .slot_out (head_out),
    .stat     (head_stat)
  );

  always_comb begin
    busy_nxt    = busy_r;
    pend_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    req_nxt     = req_r;
    taken_nxt   = taken_r;
    hit_nxt     = hit_r;
    res_id_nxt  = res_id_r;
    next_id_nxt = next_id_r;
    strobe_nxt  = 1'b0;
    kind_nxt    = kind_r;
    id_nxt      = id_r;
    found_nxt   = found_r;
    last_nxt    = last_r;

    // The final result of the previous request goes out at the edge after its
    // turn of the ring ends, which may be the edge that accepts the next one.
    if (pend_r) begin
      strobe_nxt = 1'b1;
      last_nxt   = 1'b1;
      id_nxt     = '0;
      found_nxt  = 1'b0;
      kind_nxt   = ptst_pkg::KIND_DONE;
      if (req_r.req_type == ptst_pkg::REQ_ADD) begin
        kind_nxt = taken_r ? ptst_pkg::KIND_ADDED : ptst_pkg::KIND_FULL;
        id_nxt   = taken_r ? res_id_r : '0;
      end else if (req_r.req_type == ptst_pkg::REQ_REMOVE) begin
        found_nxt = hit_r;
      end
    end

    if (accept) begin
      busy_nxt             = 1'b1;
      cnt_nxt              = '0;
      taken_nxt            = 1'b0;
      hit_nxt              = 1'b0;
      req_nxt.req_type     = in_req_type;
      req_nxt.stage        = in_stage;
      req_nxt.elapsed      = in_elapsed;
      req_nxt.first_delay  = in_first_delay;
      req_nxt.repeat_delay = in_repeat_delay;
      req_nxt.task_id      = in_task_id;
    end else if (busy_r) begin
      if (head_stat.claim) begin
        taken_nxt   = 1'b1;
        res_id_nxt  = next_id_r;
        next_id_nxt = ptst_pkg::id_after(next_id_r);
      end
      if (head_stat.match) begin
        hit_nxt = 1'b1;
      end
      if (head_stat.fire) begin
        strobe_nxt = 1'b1;
        kind_nxt   = ptst_pkg::KIND_FIRED;
        id_nxt     = ring_q[0].ident;
        found_nxt  = 1'b0;
        last_nxt   = 1'b0;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ptst_pkg::CNT_W'(ptst_pkg::SLOTS - 1)) begin
        busy_nxt = 1'b0;
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pend_r    <= 1'b0;
      strobe_r  <= 1'b0;
      next_id_r <= '0;
      cnt_r     <= '0;
    end else begin
      busy_r    <= busy_nxt;
      pend_r    <= pend_nxt;
      strobe_r  <= strobe_nxt;
      next_id_r <= next_id_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    taken_r  <= taken_nxt;
    hit_r    <= hit_nxt;
    res_id_r <= res_id_nxt;
    kind_r   <= kind_nxt;
    id_r     <= id_nxt;
    found_r  <= found_nxt;
    last_r   <= last_nxt;
  end

  assign busy            = busy_r;
  assign out_strobe      = strobe_r;
  assign out_kind        = kind_r;
  assign out_task_id_res = id_r;
  assign out_found       = found_r;
  assign out_last        = last_r;

`ifndef NO_ASSERTIONS
  // Every transaction that is not the last of its request is a firing.
  a_mid_is_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> (out_kind == ptst_pkg::KIND_FIRED))
    else $error("non-final result is not a firing");

  // The end of a ring turn is followed by the final result of that request.
  a_final_after_turn: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |=> (out_strobe && out_last))
    else $error("ring turn ended without a final result");

  // An accepted request starts a ring turn.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the ring");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the periodic timer slot table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One result transaction as seen on the out_ ports.
  typedef struct packed {
    logic [1:0]                kind;
    logic [ptst_pkg::ID_W-1:0] ident;
    logic                      found;
    logic                      last;
  } result_t;

  // One line of the directed stimulus table. A typed row carries its
  // single expected result; every other row is checked by the predictor.
  typedef struct {
    ptst_pkg::req_t req;
    int             count;
    bit             typed;
    result_t        want;
  } stim_row_t;

  // Cycles without any accepted request or result before the run is given up.
  localparam int QUIET_LIMIT = 500;
  // Floor of the signed 32-bit delay, where a tick saturates.
  localparam longint DELAY_FLOOR = -64'sd2147483648;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             in_req_type = ptst_pkg::REQ_TICK;
  logic                   in_stage = 1'b0;
  logic [30:0]            in_elapsed = '0;
  logic [30:0]            in_first_delay = '0;
  logic signed [31:0]     in_repeat_delay = '0;
  logic [23:0]            in_task_id = '0;
  logic                   out_strobe;
  logic [1:0]             out_kind;
  logic [23:0]            out_task_id_res;
  logic                   out_found;
  logic                   out_last;

  periodic_timer_slot_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_stage        (in_stage),
    .in_elapsed      (in_elapsed),
    .in_first_delay  (in_first_delay),
    .in_repeat_delay (in_repeat_delay),
    .in_task_id      (in_task_id),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_task_id_res (out_task_id_res),
    .out_found       (out_found),
    .out_last        (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The testbench's own copy of the timer table.
  logic                              tm_valid [ptst_pkg::SLOTS];
  logic                              tm_stage [ptst_pkg::SLOTS];
  logic signed [ptst_pkg::DLY_W-1:0] tm_left [ptst_pkg::SLOTS];
  logic signed [ptst_pkg::DLY_W-1:0] tm_reload [ptst_pkg::SLOTS];
  logic [ptst_pkg::ID_W-1:0]         tm_id [ptst_pkg::SLOTS];
  logic [ptst_pkg::ID_W-1:0]         tm_next_id;

  // Results of the request just applied to the table copy, and the results
  // still owed by the block, oldest first.
  result_t   step_out [$];
  result_t   due_results [$];
  stim_row_t plan [$];

  bit idle_on = 1'b1;
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_fired = 0;
  int n_full = 0;
  int n_by_req [4] = '{0, 0, 0, 0};

  function automatic result_t mk(input logic [1:0] kind,
                                 input logic [ptst_pkg::ID_W-1:0] ident,
                                 input logic found, input logic last);
    result_t r;
    r.kind = kind;
    r.ident = ident;
    r.found = found;
    r.last = last;
    return r;
  endfunction

  // Appends one result to those caused by the current request.
  function automatic void emit_step(input result_t r);
    step_out = {step_out, r};
  endfunction

  // Applies one accepted request to the table copy and leaves the results it
  // causes in step_out, in the order the block must deliver them.
  function automatic void apply_to_table(input ptst_pkg::req_t r);
    longint diff;
    bit     hit;
    int     slot;
    step_out.delete();
    case (r.req_type)
      ptst_pkg::REQ_TICK: begin
        for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
          if (tm_valid[i] && tm_stage[i] == r.stage) begin
            diff = longint'(tm_left[i]) - longint'(r.elapsed);
            if (diff < DELAY_FLOOR) diff = DELAY_FLOOR;
            tm_left[i] = diff[31:0];
            if (diff < 0) begin
              emit_step(mk(ptst_pkg::KIND_FIRED, tm_id[i], 1'b0, 1'b0));
              if (tm_reload[i] >= 0) tm_left[i] = tm_reload[i];
              else tm_valid[i] = 1'b0;
            end
          end
        end
        emit_step(mk(ptst_pkg::KIND_DONE, '0, 1'b0, 1'b1));
      end
      ptst_pkg::REQ_ADD: begin
        slot = -1;
        for (int i = ptst_pkg::SLOTS - 1; i >= 0; i--) begin
          if (!tm_valid[i]) slot = i;
        end
        if (slot < 0) begin
          emit_step(mk(ptst_pkg::KIND_FULL, '0, 1'b0, 1'b1));
        end else begin
          tm_valid[slot] = 1'b1;
          tm_stage[slot] = r.stage;
          tm_left[slot] = {1'b0, r.first_delay};
          tm_reload[slot] = r.repeat_delay;
          tm_id[slot] = tm_next_id;
          emit_step(mk(ptst_pkg::KIND_ADDED, tm_next_id, 1'b0, 1'b1));
          tm_next_id = tm_next_id + 1'b1;
          if (tm_next_id >= ptst_pkg::ID_WRAP) tm_next_id = '0;
        end
      end
      ptst_pkg::REQ_REMOVE: begin
        hit = 1'b0;
        for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
          if (!hit && tm_valid[i] && tm_id[i] == r.task_id) begin
            tm_valid[i] = 1'b0;
            hit = 1'b1;
          end
        end
        emit_step(mk(ptst_pkg::KIND_DONE, '0, hit, 1'b1));
      end
      default: begin
        for (int i = 0; i < ptst_pkg::SLOTS; i++) tm_valid[i] = 1'b0;
        emit_step(mk(ptst_pkg::KIND_DONE, '0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  task automatic plan_row(input logic [1:0] req_type, input logic stage,
                          input logic [30:0] elapsed, input logic [30:0] first_delay,
                          input logic signed [31:0] repeat_delay,
                          input logic [23:0] task_id,
                          input int count, input bit typed, input result_t want);
    stim_row_t row;
    row.req = '0;
    row.req.req_type = req_type;
    row.req.stage = stage;
    row.req.elapsed = elapsed;
    row.req.first_delay = first_delay;
    row.req.repeat_delay = repeat_delay;
    row.req.task_id = task_id;
    row.count = count;
    row.typed = typed;
    row.want = want;
    plan = {plan, row};
  endtask

  // Builds a random request. Most of them are meaningful: ticks whose elapsed
  // time is of the same order as the delays in the table, and removes aimed
  // at live ids. The fields a request does not use carry random noise.
  function automatic ptst_pkg::req_t random_request();
    ptst_pkg::req_t            r;
    int                        pick;
    logic [ptst_pkg::ID_W-1:0] live [$];
    r.req_type = ptst_pkg::REQ_TICK;
    r.stage = 1'($urandom_range(1, 0));
    r.elapsed = 31'($urandom());
    r.first_delay = 31'($urandom());
    r.repeat_delay = {1'b0, 31'($urandom())};
    r.task_id = 24'($urandom_range(9999998, 0));
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      r.req_type = ptst_pkg::REQ_TICK;
      pick = $urandom_range(9, 0);
      if (pick == 0) r.elapsed = '0;
      else if (pick > 1) r.elapsed = 31'($urandom_range(32'h30000, 0));
    end else if (pick < 75) begin
      r.req_type = ptst_pkg::REQ_ADD;
      pick = $urandom_range(9, 0);
      if (pick == 0) r.first_delay = '0;
      else if (pick > 1) r.first_delay = 31'($urandom_range(32'h40000, 0));
      pick = $urandom_range(9, 0);
      if (pick < 3) r.repeat_delay = -32'sd1;
      else if (pick < 9) r.repeat_delay = 32'($urandom_range(32'h40000, 0));
    end else if (pick < 95) begin
      r.req_type = ptst_pkg::REQ_REMOVE;
      for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
        if (tm_valid[i]) live = {live, tm_id[i]};
      end
      if (live.size() > 0 && $urandom_range(9, 0) < 7)
        r.task_id = live[$urandom_range(live.size() - 1, 0)];
    end else begin
      r.req_type = ptst_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  // Offers one request and returns at the edge where it is accepted. An idle
  // gap of a random length may come first; otherwise start stays high from
  // the previous transaction.
  task automatic issue(input ptst_pkg::req_t r);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99, 0) < 24) gap = $urandom_range(44, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type <= r.req_type;
    in_stage <= r.stage;
    in_elapsed <= r.elapsed;
    in_first_delay <= r.first_delay;
    in_repeat_delay <= r.repeat_delay;
    in_task_id <= r.task_id;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    n_by_req[r.req_type]++;
  endtask

  // Holds the sender back until every owed result has come.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input bit unexpected, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected)
        $display("%0t: result with nothing owed: kind %0d id %0d found %0d last %0d",
                 $realtime, got.kind, got.ident, got.found, got.last);
      else
        $display("%0t: expected kind %0d id %0d found %0d last %0d, got %0d %0d %0d %0d",
                 $realtime, want.kind, want.ident, want.found, want.last,
                 got.kind, got.ident, got.found, got.last);
    end
  endtask

  // Result checker. Outputs are sampled at the rising edge that ends the
  // strobe cycle, before the block's own updates at that edge land.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_strobe) begin
      got = mk(out_kind, out_task_id_res, out_found, out_last);
      if (got.kind == ptst_pkg::KIND_FIRED) n_fired++;
      if (got.kind == ptst_pkg::KIND_FULL) n_full++;
      if (due_results.size() == 0) begin
        note_mismatch(1'b1, got, got);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (got.kind !== want.kind || got.ident !== want.ident ||
            got.found !== want.found || got.last !== want.last)
          note_mismatch(1'b0, want, got);
      end
    end
  end

  // Watchdog: any accepted request or result restarts the count, so only a
  // block that has stopped talking runs into the limit.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d quiet cycles, %0d results still owed",
               quiet_cycles, due_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    ptst_pkg::req_t r;
    for (int i = 0; i < ptst_pkg::SLOTS; i++) begin
      tm_valid[i] = 1'b0;
      tm_stage[i] = 1'b0;
      tm_left[i] = '0;
      tm_reload[i] = '0;
      tm_id[i] = '0;
    end
    tm_next_id = '0;

    // Directed table. The first rows work on an empty table, where the
    // answers are obvious. Then three slots are added with the extreme
    // delays: a one-shot slot with zero delay, a periodic slot with zero
    // repeat, and an after-frame slot with the largest delay and repeat.
    // The ticks walk them over the edge of zero, where a remaining delay of
    // exactly zero must not fire and minus one must. Finally the table is
    // filled to the brim, an add is refused, and two ticks make every slot
    // fire at once, which gives the longest burst of results.
    plan_row(ptst_pkg::REQ_TICK, 1'b0, 31'd0, 31'd0, 32'sd0, 24'd0, 1, 1'b1,
             mk(ptst_pkg::KIND_DONE, '0, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_REMOVE, 1'b0, 31'd0, 31'd0, 32'sd0, 24'd0, 1, 1'b1,
             mk(ptst_pkg::KIND_DONE, '0, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_CLEAR, 1'b1, 31'h7FFFFFFF, 31'h7FFFFFFF, -32'sd1,
             24'd9999998, 1, 1'b1, mk(ptst_pkg::KIND_DONE, '0, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_ADD, 1'b0, 31'd0, 31'd0, -32'sd1, 24'd0, 1, 1'b1,
             mk(ptst_pkg::KIND_ADDED, 24'd0, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_ADD, 1'b0, 31'd0, 31'h10000, 32'sd0, 24'd0, 1, 1'b1,
             mk(ptst_pkg::KIND_ADDED, 24'd1, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_ADD, 1'b1, 31'd0, 31'h7FFFFFFF, 32'sh7FFFFFFF, 24'd0, 1, 1'b1,
             mk(ptst_pkg::KIND_ADDED, 24'd2, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_TICK, 1'b0, 31'd0, 31'd0, 32'sd0, 24'd0, 1, 1'b0, '0);
    plan_row(ptst_pkg::REQ_TICK, 1'b0, 31'd1, 31'd0, 32'sd0, 24'd0, 1, 1'b0, '0);
    plan_row(ptst_pkg::REQ_TICK, 1'b1, 31'h7FFFFFFF, 31'd0, 32'sd0, 24'd0, 1, 1'b0, '0);
    plan_row(ptst_pkg::REQ_TICK, 1'b1, 31'h7FFFFFFF, 31'd0, 32'sd0, 24'd0, 1, 1'b0, '0);
    plan_row(ptst_pkg::REQ_TICK, 1'b0, 31'h7FFFFFFF, 31'd0, 32'sd0, 24'd0, 1, 1'b0, '0);
    plan_row(ptst_pkg::REQ_REMOVE, 1'b0, 31'd0, 31'd0, 32'sd0, 24'd1, 1, 1'b1,
             mk(ptst_pkg::KIND_DONE, '0, 1'b1, 1'b1));
    plan_row(ptst_pkg::REQ_REMOVE, 1'b0, 31'd0, 31'd0, 32'sd0, 24'd1, 1, 1'b1,
             mk(ptst_pkg::KIND_DONE, '0, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_ADD, 1'b1, 31'd0, 31'd0, 32'sd0, 24'd0, ptst_pkg::SLOTS - 1,
             1'b0, '0);
    plan_row(ptst_pkg::REQ_ADD, 1'b1, 31'd0, 31'd5, 32'sd5, 24'd0, 1, 1'b1,
             mk(ptst_pkg::KIND_FULL, '0, 1'b0, 1'b1));
    plan_row(ptst_pkg::REQ_TICK, 1'b1, 31'h7FFFFFFF, 31'd0, 32'sd0, 24'd0, 1, 1'b0, '0);
    plan_row(ptst_pkg::REQ_TICK, 1'b1, 31'd1, 31'd0, 32'sd0, 24'd0, 1, 1'b0, '0);
    plan_row(ptst_pkg::REQ_CLEAR, 1'b0, 31'd0, 31'd0, 32'sd0, 24'd0, 1, 1'b1,
             mk(ptst_pkg::KIND_DONE, '0, 1'b0, 1'b1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table. The predictor runs on every row so that its copy of
    // the table stays in step; a typed row's own expectation replaces what
    // the predictor computed for it.
    foreach (plan[k]) begin
      for (int c = 0; c < plan[k].count; c++) begin
        issue(plan[k].req);
        apply_to_table(plan[k].req);
        if (plan[k].typed) due_results = {due_results, plan[k].want};
        else foreach (step_out[j]) due_results = {due_results, step_out[j]};
      end
    end
    drain();

    // Random part. Requests 80 to 149 go out back to back, with no random
    // idle gaps; now and then, and once for certain, the sender waits until
    // the block has delivered everything it owes.
    for (int n = 0; n < 220; n++) begin
      idle_on = !(n >= 80 && n < 150);
      if (n == 200 || $urandom_range(99, 0) < 3) drain();
      r = random_request();
      issue(r);
      apply_to_table(r);
      foreach (step_out[j]) due_results = {due_results, step_out[j]};
    end
    start <= 1'b0;

    while (due_results.size() > 0) @(posedge clk);
    repeat (ptst_pkg::SLOTS + 4) @(posedge clk);

    $display("Sent %0d requests: %0d ticks, %0d adds, %0d removes, %0d clears.",
             n_sent, n_by_req[ptst_pkg::REQ_TICK], n_by_req[ptst_pkg::REQ_ADD],
             n_by_req[ptst_pkg::REQ_REMOVE], n_by_req[ptst_pkg::REQ_CLEAR]);
    $display("Checked %0d results, among them %0d firings and %0d refused adds.",
             n_checked, n_fired, n_full);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
